// ----- hdl/particle_distance_field_splat_macros.svh -----
// assertion helpers shared by the splat block
`ifndef PARTICLE_DISTANCE_FIELD_SPLAT_MACROS_SVH
`define PARTICLE_DISTANCE_FIELD_SPLAT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PDFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PDFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pdfs_pkg.sv -----
`timescale 1ns / 1ps
package pdfs_pkg;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SPLAT = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_CELL_SIZE = 3'd3;
  localparam logic [2:0] REG_SHELL_RAD = 3'd4;
  localparam logic [2:0] REG_SIZE_X    = 3'd5;
  localparam logic [2:0] REG_SIZE_Y    = 3'd6;
  localparam logic [2:0] REG_SIZE_Z    = 3'd7;

  // window bound divider widths
  localparam int unsigned DIV_NUM_W = 28;
  localparam int unsigned DIV_DEN_W = 24;
  localparam int unsigned DIV_CNT_W = 5;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- hdl/pdfs_div.sv -----
`timescale 1ns / 1ps
module pdfs_div import pdfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_NUM_W-1:0] quot_o,
  output div_status_t          status_o
);

  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DEN_W:0]   shift_rem;
  logic                 fits;

  // one restoring step per cycle
  assign shift_rem = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits      = shift_rem >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
      rem_q <= fits ? DIV_DEN_W'(shift_rem - {1'b0, den_q}) : shift_rem[DIV_DEN_W-1:0];
    end
  end

  assign quot_o        = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ----- hdl/particle_distance_field_splat.sv -----
// Minimum squared distance field over a 3-D grid of cell corners.
// Input stream: s_axis_tuser selects the command (clear, splat, read),
// s_axis_tdata carries the particle position or the cell index. A word is
// taken when tvalid and tready are both high; tready is low while a command
// is being worked on. Only a read gives an output word (m_axis_tdata is the
// distance minus the shell radius, m_axis_tuser flags an index outside the grid).
// Clear: writes every cell, one per cycle, through the single memory write port.
// A clear must come before use.
// Splat: six window bounds through one serial divider, then a memory
// read-modify-write for each cell in the window, with extra squaring steps
// at each new row and plane.
// Read: a serial square root (one result bit a cycle) of the stored value.
// The result sits in an output register; a stalled receiver holds it there and
// a second read waits for it to be taken, but other commands proceed.
// Reset clears the sequencer and loads the default configuration; the cell
// memory contents are unknown until the first clear.
`timescale 1ns / 1ps
`include "particle_distance_field_splat_macros.svh"
module particle_distance_field_splat import pdfs_pkg::*; #(
  parameter int GRID_X_MAX = 32,
  parameter int GRID_Y_MAX = 32,
  parameter int GRID_Z_MAX = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], cell_i[76:72], cell_j[81:77],
  // cell_k[86:82], zero[87]
  input  logic [87:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // phi_value[23:0]
  output logic [23:0] m_axis_tdata,
  // index_error[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int CELLS  = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [8:0] GMAX_X = 9'(GRID_X_MAX);
  localparam logic [8:0] GMAX_Y = 9'(GRID_Y_MAX);
  localparam logic [8:0] GMAX_Z = 9'(GRID_Z_MAX);
  localparam logic [47:0] D2_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR_MUL, ST_CLEAR, ST_DIV_GO, ST_DIV, ST_WIN, ST_OFF,
    ST_SQZ, ST_SQY, ST_CELL_A, ST_CELL_B, ST_RD_MEM, ST_SQ_INIT, ST_SQ_RUN,
    ST_PHI, ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic signed [23:0] org_q [3];
  logic [22:0]        cs_q;
  logic [22:0]        rad_q;
  logic [5:0]         size_q [3];

  // splat working registers
  logic signed [24:0] rel_q [3];
  logic [8:0]         lo_q [3];
  logic [8:0]         hi_q [3];
  logic               hemp_q [3];
  logic [8:0]         cur_q [3];
  logic signed [33:0] d0_q [3];
  logic signed [33:0] d_q [3];
  logic [48:0]        sqx_q, sqy_q, sqz_q;
  logic [2:0]         div_sel_q;
  logic [1:0]         off_sel_q;
  logic [47:0]        fill_q;
  logic [ADDR_W-1:0]  clr_q;

  // read working registers
  logic [ADDR_W-1:0]  rd_addr_q;
  logic [47:0]        sv_q, sr_q, sbit_q;
  logic [4:0]         scnt_q;
  logic               err_q;

  // output register
  logic               m_valid_q;
  logic [23:0]        out_phi_q;
  logic               out_err_q;

  // memory
  logic [47:0]        mem [CELLS];
  logic [47:0]        rdata_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr, cell_addr, rd_addr_d;
  logic [47:0]        mem_wdata;

  logic [22:0]        cs_eff;
  logic [8:0]         n_ax [3];
  logic [26:0]        reach;
  logic [1:0]         div_ax;
  logic signed [27:0] num;
  logic               num_neg;
  logic [27:0]        num_mag;
  logic [27:0]        quot;
  div_status_t        div_st;
  logic [8:0]         lo_new, hi_new;
  logic               hemp_new;
  logic [33:0]        dabs [3];
  logic               dovf [3];
  logic [23:0]        mul_a, mul_b;
  logic [47:0]        prod;
  logic [49:0]        d2_sum;
  logic [47:0]        d2;
  logic               win_empty;
  logic [48:0]        sq_trial;
  logic signed [24:0] phi_diff;
  logic [4:0]         ci, cj, ck;
  logic               rd_err;
  logic               accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // effective configuration
  assign cs_eff  = (cs_q == '0) ? 23'd1 : cs_q;
  assign n_ax[0] = ({3'b0, size_q[0]} > GMAX_X) ? GMAX_X : {3'b0, size_q[0]};
  assign n_ax[1] = ({3'b0, size_q[1]} > GMAX_Y) ? GMAX_Y : {3'b0, size_q[1]};
  assign n_ax[2] = ({3'b0, size_q[2]} > GMAX_Z) ? GMAX_Z : {3'b0, size_q[2]};
  assign reach   = 27'({rad_q, 1'b0}) + 27'({cs_eff, 1'b0}) + 27'(cs_eff);

  // window bound numerator, doubled so the half cell stays exact
  assign div_ax  = div_sel_q[2:1];
  assign num     = div_sel_q[0] ?
                   28'($signed({rel_q[div_ax], 1'b0})) + $signed({1'b0, reach}) :
                   28'($signed({rel_q[div_ax], 1'b0})) - $signed({1'b0, reach});
  assign num_neg = num[27];
  assign num_mag = num_neg ? 28'(-num) : 28'(num);

  pdfs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_DIV_GO),
    .num_i    (num_mag),
    .den_i    ({cs_eff, 1'b0}),
    .quot_o   (quot),
    .status_o (div_st)
  );

  // clamp truncated quotient into a window bound
  always_comb begin
    lo_new   = 9'd0;
    hi_new   = 9'd0;
    hemp_new = 1'b0;
    if (!num_neg && quot != '0) begin
      lo_new = (quot > 28'd255) ? 9'd256 : quot[8:0];
    end
    if (num_neg && quot != '0) begin
      hemp_new = 1'b1;
    end else if (n_ax[div_ax] == '0) begin
      hemp_new = 1'b1;
    end else if (quot > 28'(n_ax[div_ax] - 9'd1)) begin
      hi_new = n_ax[div_ax] - 9'd1;
    end else begin
      hi_new = quot[8:0];
    end
  end

  // per axis offset magnitudes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dabs[a] = d_q[a][33] ? 34'(-d_q[a]) : 34'(d_q[a]);
      dovf[a] = |dabs[a][33:24];
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CLR_MUL: begin mul_a = 24'(rad_q); mul_b = 24'(rad_q); end
      ST_OFF:     begin mul_a = 24'(cs_eff); mul_b = 24'(lo_q[off_sel_q]); end
      ST_SQZ:     begin mul_a = dabs[2][23:0]; mul_b = dabs[2][23:0]; end
      ST_SQY:     begin mul_a = dabs[1][23:0]; mul_b = dabs[1][23:0]; end
      ST_CELL_A:  begin mul_a = dabs[0][23:0]; mul_b = dabs[0][23:0]; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // squared distance, saturated
  assign d2_sum = 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);
  assign d2     = (d2_sum > 50'(D2_MAX)) ? D2_MAX : d2_sum[47:0];

  assign win_empty = hemp_q[0] || hemp_q[1] || hemp_q[2] ||
                     (lo_q[0] > hi_q[0]) || (lo_q[1] > hi_q[1]) || (lo_q[2] > hi_q[2]);

  // addresses
  assign ci = s_axis_tdata[76:72];
  assign cj = s_axis_tdata[81:77];
  assign ck = s_axis_tdata[86:82];
  assign rd_err = ({4'b0, ci} >= n_ax[0]) || ({4'b0, cj} >= n_ax[1]) ||
                  ({4'b0, ck} >= n_ax[2]);
  assign cell_addr = ADDR_W'(cur_q[0]) + ADDR_W'(GRID_X_MAX) *
                     (ADDR_W'(cur_q[1]) + ADDR_W'(GRID_Y_MAX) * ADDR_W'(cur_q[2]));
  assign rd_addr_d = ADDR_W'(ci) + ADDR_W'(GRID_X_MAX) *
                     (ADDR_W'(cj) + ADDR_W'(GRID_Y_MAX) * ADDR_W'(ck));

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_CELL_B) && (d2 < rdata_q));
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : cell_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? fill_q : d2;
  assign mem_raddr = (state_q == ST_RD_MEM) ? rd_addr_q : cell_addr;

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // square root step and result
  assign sq_trial = 49'(sr_q) + 49'(sbit_q);
  assign phi_diff = $signed({1'b0, sr_q[23:0]}) - $signed({2'b0, rad_q});

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      org_q[0]  <= '0;
      org_q[1]  <= '0;
      org_q[2]  <= '0;
      cs_q      <= 23'd1229;
      rad_q     <= 23'd4096;
      size_q[0] <= 6'd32;
      size_q[1] <= 6'd32;
      size_q[2] <= 6'd32;
      m_valid_q <= 1'b0;
      clr_q     <= '0;
      div_sel_q <= '0;
      off_sel_q <= '0;
      scnt_q    <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X:  org_q[0]  <= cfg_data_i;
          REG_ORIGIN_Y:  org_q[1]  <= cfg_data_i;
          REG_ORIGIN_Z:  org_q[2]  <= cfg_data_i;
          REG_CELL_SIZE: cs_q      <= cfg_data_i[22:0];
          REG_SHELL_RAD: rad_q     <= cfg_data_i[22:0];
          REG_SIZE_X:    size_q[0] <= cfg_data_i[5:0];
          REG_SIZE_Y:    size_q[1] <= cfg_data_i[5:0];
          REG_SIZE_Z:    size_q[2] <= cfg_data_i[5:0];
          default:       ;
        endcase
      end

      // output valid: load a new word or drop the taken one
      if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (s_axis_tuser)
              CMD_CLEAR: state_q <= ST_CLR_MUL;
              CMD_SPLAT: begin
                rel_q[0]  <= 25'($signed(s_axis_tdata[23:0])) - 25'(org_q[0]);
                rel_q[1]  <= 25'($signed(s_axis_tdata[47:24])) - 25'(org_q[1]);
                rel_q[2]  <= 25'($signed(s_axis_tdata[71:48])) - 25'(org_q[2]);
                div_sel_q <= '0;
                state_q   <= ST_DIV_GO;
              end
              CMD_READ: begin
                rd_addr_q <= rd_addr_d;
                err_q     <= rd_err;
                state_q   <= rd_err ? ST_OUT : ST_RD_MEM;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        // clear sweep
        ST_CLR_MUL: begin
          fill_q  <= {prod[46:0], 1'b0};
          clr_q   <= '0;
          state_q <= ST_CLEAR;
        end
        ST_CLEAR: begin
          if (clr_q == ADDR_W'(CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        // window bounds
        ST_DIV_GO: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_st.done) begin
            if (div_sel_q[0]) begin
              hi_q[div_ax]   <= hi_new;
              hemp_q[div_ax] <= hemp_new;
            end else begin
              lo_q[div_ax] <= lo_new;
            end
            div_sel_q <= div_sel_q + 1'b1;
            state_q   <= (div_sel_q == 3'd5) ? ST_WIN : ST_DIV_GO;
          end
        end
        ST_WIN: begin
          off_sel_q <= '0;
          state_q   <= win_empty ? ST_IDLE : ST_OFF;
        end
        // corner offsets of the first cell
        ST_OFF: begin
          d0_q[off_sel_q]  <= 34'(rel_q[off_sel_q]) - $signed({1'b0, prod[32:0]});
          d_q[off_sel_q]   <= 34'(rel_q[off_sel_q]) - $signed({1'b0, prod[32:0]});
          cur_q[off_sel_q] <= lo_q[off_sel_q];
          off_sel_q        <= off_sel_q + 1'b1;
          if (off_sel_q == 2'd2) begin
            state_q <= ST_SQZ;
          end
        end
        ST_SQZ: begin
          sqz_q   <= {dovf[2], prod};
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          sqy_q   <= {dovf[1], prod};
          state_q <= ST_CELL_A;
        end
        ST_CELL_A: begin
          sqx_q   <= {dovf[0], prod};
          state_q <= ST_CELL_B;
        end
        // min update done by the write port, step the window
        ST_CELL_B: begin
          if (cur_q[0] < hi_q[0]) begin
            cur_q[0] <= cur_q[0] + 1'b1;
            d_q[0]   <= d_q[0] - 34'(cs_eff);
            state_q  <= ST_CELL_A;
          end else begin
            cur_q[0] <= lo_q[0];
            d_q[0]   <= d0_q[0];
            if (cur_q[1] < hi_q[1]) begin
              cur_q[1] <= cur_q[1] + 1'b1;
              d_q[1]   <= d_q[1] - 34'(cs_eff);
              state_q  <= ST_SQY;
            end else begin
              cur_q[1] <= lo_q[1];
              d_q[1]   <= d0_q[1];
              if (cur_q[2] < hi_q[2]) begin
                cur_q[2] <= cur_q[2] + 1'b1;
                d_q[2]   <= d_q[2] - 34'(cs_eff);
                state_q  <= ST_SQZ;
              end else begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        // read and square root
        ST_RD_MEM: state_q <= ST_SQ_INIT;
        ST_SQ_INIT: begin
          sv_q    <= rdata_q;
          sr_q    <= '0;
          sbit_q  <= 48'h4000_0000_0000;
          scnt_q  <= '0;
          state_q <= ST_SQ_RUN;
        end
        ST_SQ_RUN: begin
          if ({1'b0, sv_q} >= sq_trial) begin
            sv_q <= sv_q - sq_trial[47:0];
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
          scnt_q <= scnt_q + 1'b1;
          if (scnt_q == 5'd23) begin
            state_q <= ST_PHI;
          end
        end
        ST_PHI: begin
          if (phi_diff > 25'sd8388607) begin
            sv_q[23:0] <= 24'h7F_FFFF;
          end else if (phi_diff < -25'sd8388608) begin
            sv_q[23:0] <= 24'h80_0000;
          end else begin
            sv_q[23:0] <= phi_diff[23:0];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            out_phi_q <= err_q ? 24'd0 : sv_q[23:0];
            out_err_q <= err_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_phi_q;
  assign m_axis_tuser  = out_err_q;

  `PDFS_ASSERT_IMP(a_we_state, mem_we, (state_q == ST_CLEAR) || (state_q == ST_CELL_B), "memory write outside clear or cell update")
  `PDFS_ASSERT_IMP(a_we_smaller, mem_we && (state_q == ST_CELL_B), mem_wdata < rdata_q, "cell update does not lower the stored distance")
  `PDFS_ASSERT_IMP(a_in_window, state_q == ST_CELL_A, (cur_q[0] <= hi_q[0]) && (cur_q[1] <= hi_q[1]) && (cur_q[2] <= hi_q[2]), "cell index beyond window")
  `PDFS_ASSERT_IMP(a_div_done, div_st.done, state_q == ST_DIV, "divider finished while not awaited")

endmodule
